@@ rtl/scanline_edge_setup_defines.svh @@
// Assertion macros used by the scanline edge setup RTL.
`ifndef SCANLINE_EDGE_SETUP_DEFINES_SVH
`define SCANLINE_EDGE_SETUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scanline_edge_setup: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scanline_edge_setup: next-cycle check failed");

`endif

@@ rtl/ses_pkg.sv @@
// Package with the controller states and the command and status structs.
`default_nettype none

package ses_pkg;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_PICK,
    S_DIV,
    S_WRITE
  } ses_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // Input transfer happens this cycle.
    logic start;     // Set up an edge and load the divider.
    logic edge_sel;  // 0: previous to current vertex, 1: current back to first.
    logic step;      // One quotient bit.
    logic load_out;  // Move the finished record into the output register.
  } ses_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_a_en;  // Edge from the previous vertex is not horizontal.
    logic edge_b_en;  // Closing edge exists and is not horizontal.
    logic div_done;   // All quotient bits are in.
    logic out_free;   // Output register can take a record this cycle.
  } ses_status_t;

endpackage

`default_nettype wire

@@ rtl/ses_if.sv @@
// Valid/ready channel interfaces for vertices in and edge records out.
`default_nettype none

interface ses_vertex_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] vertex_x;
  logic [COORD_BITS-1:0] vertex_y;
  logic                  closes_polygon;

  modport source (output valid, output vertex_x, output vertex_y, output closes_polygon,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input closes_polygon,
                output ready);
endinterface

interface ses_edge_if #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
);
  localparam int SlopeBits = COORD_BITS + FRAC_BITS + 1;

  logic                        valid;
  logic                        ready;
  logic [COORD_BITS-1:0]       lower_y;
  logic [COORD_BITS-1:0]       upper_y;
  logic [COORD_BITS-1:0]       start_x;
  logic signed [SlopeBits-1:0] inverse_slope;
  logic                        last_edge;

  modport source (output valid, output lower_y, output upper_y, output start_x,
                  output inverse_slope, output last_edge, input ready);
  modport sink (input valid, input lower_y, input upper_y, input start_x,
                input inverse_slope, input last_edge, output ready);
endinterface

`default_nettype wire

@@ rtl/ses_ctrl.sv @@
// Controller state machine that sequences edge setup, division and output.
`default_nettype none

`include "scanline_edge_setup_defines.svh"

module ses_ctrl
  import ses_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire ses_status_t status,
  output ses_cmd_t         cmd
);

  ses_state_t state_r, state_nxt;
  logic       edge_sel_r, edge_sel_nxt;

  // State and edge select registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      edge_sel_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      edge_sel_r <= edge_sel_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt    = state_r;
    edge_sel_nxt = edge_sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PICK;
      end
      S_PICK: begin
        if (status.edge_a_en) begin
          state_nxt    = S_DIV;
          edge_sel_nxt = 1'b0;
        end else if (status.edge_b_en) begin
          state_nxt    = S_DIV;
          edge_sel_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (status.div_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          if (!edge_sel_r && status.edge_b_en) begin
            state_nxt    = S_DIV;
            edge_sel_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.edge_sel = edge_sel_r;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_PICK: begin
        cmd.start    = status.edge_a_en || status.edge_b_en;
        cmd.edge_sel = !status.edge_a_en;
      end
      S_DIV: begin
        cmd.step = !status.div_done;
      end
      S_WRITE: begin
        cmd.load_out = status.out_free;
        if (status.out_free && !edge_sel_r && status.edge_b_en) begin
          cmd.start    = 1'b1;
          cmd.edge_sel = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // A fresh division always has quotient bits left to produce.
  `SES_ASSERT_NEXT(a_start_not_done, clk, rst_n, cmd.start, !status.div_done)
  // A record is only moved out when the output register can take it.
  `SES_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, status.out_free)
  // An accepted vertex is always examined in the following cycle.
  `SES_ASSERT_NEXT(a_accept_then_pick, clk, rst_n, cmd.accept, state_r == S_PICK)

endmodule

`default_nettype wire

@@ rtl/ses_datapath.sv @@
// Datapath: vertex state, edge setup, restoring divider and output register.
`default_nettype none

module ses_datapath
  import ses_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ses_cmd_t      cmd,
  output ses_status_t        status,
  ses_vertex_if.sink         in_vtx,
  ses_edge_if.source         out_edge
);

  localparam int QuoBits   = COORD_BITS + FRAC_BITS;
  localparam int SlopeBits = QuoBits + 1;
  localparam int CntBits   = $clog2(QuoBits + 1);

  // Vertex state and the latched input vertex.
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [COORD_BITS-1:0] first_x_r, first_y_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic [COORD_BITS-1:0] old_x_r, old_y_r;
  logic                  closes_r, have_prev_r;
  logic                  edge_a_en_r, edge_b_en_r;

  // Edge under division.
  logic                  edge_sel_r, neg_r;
  logic [COORD_BITS-1:0] lo_y_r, hi_y_r, sx_r, ady_r, rem_r;
  logic [QuoBits-1:0]    quo_r;
  logic [CntBits-1:0]    cnt_r;

  // Output register.
  logic                        out_valid_r;
  logic [COORD_BITS-1:0]       out_lo_r, out_hi_r, out_sx_r;
  logic signed [SlopeBits-1:0] out_slope_r;
  logic                        out_last_r;

  // Edge setup from the selected endpoints.
  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] set_lo, set_hi, set_sx, set_adx, set_ady;
  logic                  set_neg;

  always_comb begin
    if (cmd.edge_sel) begin
      ax = cur_x_r;
      ay = cur_y_r;
      bx = first_x_r;
      by = first_y_r;
    end else begin
      ax = old_x_r;
      ay = old_y_r;
      bx = cur_x_r;
      by = cur_y_r;
    end
    if (by > ay) begin
      set_lo  = ay;
      set_hi  = by;
      set_sx  = ax;
      set_ady = by - ay;
    end else begin
      set_lo  = by;
      set_hi  = ay;
      set_sx  = bx;
      set_ady = ay - by;
    end
    set_adx = (bx >= ax) ? (bx - ax) : (ax - bx);
    set_neg = (bx < ax) ^ (by < ay);
  end

  // One restoring division step.
  logic [COORD_BITS:0]   trial;
  logic                  qbit;
  logic [COORD_BITS-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[QuoBits-1]};
    qbit    = (trial >= {1'b0, ady_r});
    rem_nxt = qbit ? COORD_BITS'(trial - {1'b0, ady_r}) : trial[COORD_BITS-1:0];
  end

  // Vertex bookkeeping on an input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      first_x_r   <= '0;
      first_y_r   <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      edge_a_en_r <= 1'b0;
      edge_b_en_r <= 1'b0;
    end else if (cmd.accept) begin
      cur_x_r     <= in_vtx.vertex_x;
      cur_y_r     <= in_vtx.vertex_y;
      closes_r    <= in_vtx.closes_polygon;
      old_x_r     <= prev_x_r;
      old_y_r     <= prev_y_r;
      prev_x_r    <= in_vtx.vertex_x;
      prev_y_r    <= in_vtx.vertex_y;
      have_prev_r <= !in_vtx.closes_polygon;
      edge_a_en_r <= have_prev_r && (prev_y_r != in_vtx.vertex_y);
      edge_b_en_r <= have_prev_r && in_vtx.closes_polygon && (first_y_r != in_vtx.vertex_y);
      if (!have_prev_r) begin
        first_x_r <= in_vtx.vertex_x;
        first_y_r <= in_vtx.vertex_y;
      end
    end
  end

  // Divider: load on start, then one quotient bit per step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r      <= CntBits'(QuoBits);
      edge_sel_r <= cmd.edge_sel;
      lo_y_r     <= set_lo;
      hi_y_r     <= set_hi;
      sx_r       <= set_sx;
      neg_r      <= set_neg;
      ady_r      <= set_ady;
      rem_r      <= '0;
      quo_r      <= {set_adx, {FRAC_BITS{1'b0}}};
    end else if (cmd.step) begin
      cnt_r <= cnt_r - CntBits'(1);
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QuoBits-2:0], qbit};
    end
  end

  // Output register with its transfer handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_edge.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load_out) begin
        out_lo_r    <= lo_y_r;
        out_hi_r    <= hi_y_r;
        out_sx_r    <= sx_r;
        out_slope_r <= neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
        out_last_r  <= edge_sel_r || (closes_r && !edge_b_en_r);
      end
    end
  end

  assign status.edge_a_en = edge_a_en_r;
  assign status.edge_b_en = edge_b_en_r;
  assign status.div_done  = (cnt_r == '0);
  assign status.out_free  = !out_valid_r || out_edge.ready;

  assign out_edge.valid         = out_valid_r;
  assign out_edge.lower_y       = out_lo_r;
  assign out_edge.upper_y       = out_hi_r;
  assign out_edge.start_x       = out_sx_r;
  assign out_edge.inverse_slope = out_slope_r;
  assign out_edge.last_edge     = out_last_r;

endmodule

`default_nettype wire

@@ rtl/scanline_edge_setup.sv @@
// Top level of the scanline polygon fill edge setup block.
`default_nettype none

// Takes polygon vertices one per transfer and emits one record per non-horizontal
// edge, with the inverse slope computed by a restoring divider that produces one
// quotient bit per cycle (COORD_BITS + FRAC_BITS bits, 28 at the defaults). A vertex
// that yields no edge passes from the idle to the pick state and back; each edge
// record passes through the division and write states. The next vertex is accepted
// once the current one is finished. One output register holds a finished record,
// so a stalled consumer holds the block only when a second record is ready to be
// written.
module scanline_edge_setup
  import ses_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ses_vertex_if.sink in_vtx,
  ses_edge_if.source out_edge
);

  ses_cmd_t    cmd;
  ses_status_t status;
  logic        ctrl_ready;

  // Sequencer.
  ses_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_vtx.valid),
    .in_ready (ctrl_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The controller takes a vertex only while it is idle.
  assign in_vtx.ready = ctrl_ready;

  // Vertex state, divider and output register.
  ses_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_vtx   (in_vtx),
    .out_edge (out_edge)
  );

endmodule

`default_nettype wire
